// ----- sv/tbps_pkg.sv -----
// ----------------------------------------------------------------------------
// tbps_pkg
// Shared types, constants and the size table of the token bucket shaper.
// ----------------------------------------------------------------------------
package tbps_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TOKEN_BITS_DEF  = 16;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_MODE   = 2'd2;

  localparam logic [15:0] TOKEN_LIMIT_RST = 16'd2500;
  localparam logic [4:0]  QUEUE_LIMIT_RST = 5'd4;
  localparam logic        BYTE_MODE_RST   = 1'b1;

  typedef enum logic [1:0] {
    CMD_ARRIVAL = 2'd0,
    CMD_TOKEN   = 2'd1,
    CMD_DRIP    = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] size_code;
  } in_item_t;

  typedef struct packed {
    logic        dropped;
    logic        unit_sent;
    logic        packet_done;
    logic [15:0] tokens_now;
    logic [4:0]  queued_now;
    logic [11:0] bytes_left;
  } out_item_t;

  typedef struct packed {
    logic [15:0] token_limit;
    logic [4:0]  queue_limit;
    logic        byte_mode;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic       not_empty;
    logic       at_limit;
    logic [2:0] head_code;
  } fifo_stat_t;

  function automatic logic [11:0] code_bytes(logic [2:0] code);
    logic [11:0] bytes;
    case (code)
      3'd0:    bytes = 12'd500;
      3'd1:    bytes = 12'd1000;
      3'd2:    bytes = 12'd1500;
      3'd3:    bytes = 12'd2000;
      default: bytes = 12'd2500;
    endcase
    return bytes;
  endfunction

endpackage

// ----- sv/token_bucket_packet_shaper_core.sv -----
// ----------------------------------------------------------------------------
// token_bucket_packet_shaper_core
// Token bucket shaper: arrivals, token ticks and drip ticks, one result each.
// ----------------------------------------------------------------------------
//  channel  signals                          direction
//  input    in_valid_i/in_ready_o/in_item_i   item in
//  output   out_valid_o/out_ready_i/out_item_o item out
//  config   cfg_we_i/cfg_idx_i/cfg_wdata_i    register write
//
//  one item per cycle sustained while out_ready_i holds; an item moves
//  from the input register into the result register, then waits until taken
//  the input register advances whenever the result register is empty or taken
//  reset clears counters and queue pointers; queue entries are never cleared
//  a stalled output holds its item and the input side fills one item deep
// ----------------------------------------------------------------------------
module token_bucket_packet_shaper_core #(
  parameter int unsigned QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TOKEN_BITS  = tbps_pkg::TOKEN_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tbps_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tbps_pkg::out_item_t                out_item_o,
  input  logic                               cfg_we_i,
  input  logic [tbps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tbps_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import tbps_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cfg_t             cfg_q;
  in_item_t         in_q;
  logic             in_valid_q;
  out_item_t        out_q, res;
  logic             out_valid_q;
  logic             adv;
  fifo_ctrl_t       fifo_ctrl;
  fifo_stat_t       fifo_stat;
  logic [CNT_W-1:0] count_nxt;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.token_limit <= TOKEN_LIMIT_RST;
      cfg_q.queue_limit <= QUEUE_LIMIT_RST;
      cfg_q.byte_mode   <= BYTE_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOKEN_LIMIT: cfg_q.token_limit <= cfg_wdata_i;
        CFG_QUEUE_LIMIT: cfg_q.queue_limit <= cfg_wdata_i[4:0];
        CFG_BYTE_MODE:   cfg_q.byte_mode   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  tbps_size_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (fifo_ctrl),
    .push_code_i  (in_q.size_code),
    .queue_limit_i(cfg_q.queue_limit),
    .stat_o       (fifo_stat),
    .count_nxt_o  (count_nxt)
  );

  tbps_event_unit #(
    .TOKEN_BITS(TOKEN_BITS),
    .CNT_W     (CNT_W)
  ) u_event (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .item_i     (in_q),
    .cfg_i      (cfg_q),
    .stat_i     (fifo_stat),
    .count_nxt_i(count_nxt),
    .ctrl_o     (fifo_ctrl),
    .res_o      (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- sv/tbps_size_fifo.sv -----
// ----------------------------------------------------------------------------
// tbps_size_fifo
// Queue of packet size codes with a registered head read and a fill count.
// ----------------------------------------------------------------------------
module tbps_size_fifo #(
  parameter int unsigned QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tbps_pkg::fifo_ctrl_t ctrl_i,
  input  logic [2:0]           push_code_i,
  input  logic [4:0]           queue_limit_i,
  output tbps_pkg::fifo_stat_t stat_o,
  output logic [CNT_W-1:0]     count_nxt_o
);
  import tbps_pkg::*;

  localparam int unsigned LW = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  logic [2:0]       mem [QUEUE_DEPTH];
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [2:0]       head_code_q;
  logic [LW-1:0]    limit_ext, count_ext, limit_eff;

  function automatic logic [IDX_W-1:0] ptr_inc(logic [IDX_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_d  = ctrl_i.pop ? ptr_inc(head_q) : head_q;
    tail_d  = ctrl_i.push ? ptr_inc(tail_q) : tail_q;
    count_d = count_q;
    if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (!ctrl_i.push && ctrl_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    limit_ext = LW'(queue_limit_i);
    count_ext = LW'(count_q);
    limit_eff = (limit_ext > DEPTH_L) ? DEPTH_L : limit_ext;
  end

  assign count_nxt_o      = count_d;
  assign stat_o.not_empty = (count_q != '0);
  assign stat_o.at_limit  = (count_ext >= limit_eff);
  assign stat_o.head_code = head_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= push_code_i;
    end
  end

  // head read for the next item, with bypass of a write into the new head
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (tail_q == head_d)) begin
      head_code_q <= push_code_i;
    end else begin
      head_code_q <= mem[head_d];
    end
  end

  a_pop_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> (count_q != '0))
    else $error("pop from empty size queue");

  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> (count_ext < DEPTH_L))
    else $error("push into full size queue");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.push && !ctrl_i.pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("fill count did not follow push");

endmodule

// ----- sv/tbps_event_unit.sv -----
// ----------------------------------------------------------------------------
// tbps_event_unit
// Token and byte counters and the per-event decision logic.
// ----------------------------------------------------------------------------
module tbps_event_unit #(
  parameter int unsigned TOKEN_BITS = tbps_pkg::TOKEN_BITS_DEF,
  parameter int unsigned CNT_W      = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  tbps_pkg::in_item_t   item_i,
  input  tbps_pkg::cfg_t       cfg_i,
  input  tbps_pkg::fifo_stat_t stat_i,
  input  logic [CNT_W-1:0]     count_nxt_i,
  output tbps_pkg::fifo_ctrl_t ctrl_o,
  output tbps_pkg::out_item_t  res_o
);
  import tbps_pkg::*;

  localparam int unsigned CW = (TOKEN_BITS > 16) ? TOKEN_BITS : 16;
  localparam logic [CW-1:0] TOK_MAX = CW'({TOKEN_BITS{1'b1}});

  logic [TOKEN_BITS-1:0] token_q, token_d;
  logic [11:0]           bytes_q, bytes_d;
  logic [CW-1:0]         tok_ext, lim_ext, cap_ext, need_ext;
  logic                  dropped, sent, done, push, pop;

  always_comb begin
    tok_ext  = CW'(token_q);
    lim_ext  = CW'(cfg_i.token_limit);
    cap_ext  = (lim_ext < TOK_MAX) ? lim_ext : TOK_MAX;
    need_ext = CW'(code_bytes(stat_i.head_code));
    token_d  = token_q;
    bytes_d  = bytes_q;
    dropped  = 1'b0;
    sent     = 1'b0;
    done     = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    case (item_i.cmd)
      CMD_ARRIVAL: begin
        if (stat_i.at_limit) begin
          dropped = 1'b1;
        end else begin
          push = 1'b1;
        end
      end
      CMD_TOKEN: begin
        if (tok_ext < cap_ext) begin
          token_d = token_q + 1'b1;
        end
      end
      CMD_DRIP: begin
        if (!cfg_i.byte_mode) begin
          if (stat_i.not_empty && (token_q != '0)) begin
            pop     = 1'b1;
            token_d = token_q - 1'b1;
            sent    = 1'b1;
            done    = 1'b1;
          end
        end else if (bytes_q != '0) begin
          if (token_q != '0) begin
            bytes_d = bytes_q - 1'b1;
            token_d = token_q - 1'b1;
            sent    = 1'b1;
            done    = (bytes_q == 12'd1);
          end
        end else if (stat_i.not_empty) begin
          if (need_ext <= tok_ext) begin
            pop     = 1'b1;
            bytes_d = code_bytes(stat_i.head_code);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign ctrl_o.push = adv_i && push;
  assign ctrl_o.pop  = adv_i && pop;

  assign res_o.dropped     = dropped;
  assign res_o.unit_sent   = sent;
  assign res_o.packet_done = done;
  assign res_o.tokens_now  = 16'(token_d);
  assign res_o.queued_now  = 5'(count_nxt_i);
  assign res_o.bytes_left  = bytes_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= '0;
      bytes_q <= '0;
    end else if (adv_i) begin
      token_q <= token_d;
      bytes_q <= bytes_d;
    end
  end

endmodule
